// ===== hw/rtl/rsd_pkg.sv =====
// Shared types and constants for the run-length sprite pixel decoder.
// Used by the decoder core and the top level; depends on nothing.
`default_nettype none

package rsd_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SIZE_W      = 12;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned RUN_W       = 12;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned RUN_LIMIT   = 3076;
  localparam int unsigned HEADER_BYTES = 4;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TRUNCATED = 3'd1,
    ERR_BLANK_BIG = 3'd2,
    ERR_COUNT_BIG = 3'd3,
    ERR_SHORT     = 3'd4,
    ERR_INDEX     = 3'd5
  } error_t;

  typedef struct packed {
    logic                 pixel_valid;
    logic [INDEX_W-1:0]   pixel_index;
    logic [BYTE_W-1:0]    red;
    logic [BYTE_W-1:0]    green;
    logic [BYTE_W-1:0]    blue;
    logic [BYTE_W-1:0]    alpha;
    logic                 finished;
    error_t               error_code;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

// ===== hw/rtl/rsd_fifo.sv =====
// Small register-based queue with count, used for the byte and result queues.
// Standalone; no package dependency.
`default_nettype none

module rsd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rsd_decode.sv =====
// Decoder core: takes bytes from the byte queue, walks the run headers and
// RGB triplets, and pushes pixel, finish and error results. Uses rsd_pkg.
`default_nettype none

module rsd_decode
  import rsd_pkg::*;
#(
  parameter int unsigned IMAGE_SIDE = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic [SIZE_W-1:0] cfg_size,
  input  wire logic              in_valid,
  input  wire logic [BYTE_W-1:0] in_byte,
  output logic                   in_take,
  input  wire logic              out_full,
  output logic                   out_push,
  output result_t                out_item
);

  localparam int unsigned PIXELS = IMAGE_SIDE * IMAGE_SIDE;

  typedef enum logic [2:0] {
    PH_BLANK_LO,
    PH_BLANK_HI,
    PH_COUNT_LO,
    PH_COUNT_HI,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_t;

  phase_t              phase, phase_next;
  logic [SIZE_W-1:0]   bytes_left, bytes_left_next;
  logic [POS_W-1:0]    pixel_position, pixel_position_next;
  logic [RUN_W-1:0]    run_left, run_left_next;
  logic [BYTE_W-1:0]   low_byte_hold, low_byte_hold_next;
  logic [BYTE_W-1:0]   red_hold, red_hold_next;
  logic [BYTE_W-1:0]   green_hold, green_hold_next;
  logic                halted, halted_next;

  logic [2*BYTE_W-1:0] run_value;
  logic [POS_W:0]      pos_sum;
  logic [SIZE_W-1:0]   bytes_dec;
  logic [17:0]         triple;
  logic [RUN_W-1:0]    run_dec;
  logic                fail;
  error_t              fail_code;
  logic                pix;

  assign in_take   = in_valid && !out_full;
  assign run_value = {in_byte, low_byte_hold};
  assign pos_sum   = {1'b0, pixel_position} + (POS_W + 1)'(run_value);
  assign bytes_dec = bytes_left - 1'b1;
  assign triple    = 18'(run_value) * 18'd3;
  assign run_dec   = (run_left != '0) ? run_left - 1'b1 : run_left;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    pixel_position_next = pixel_position;
    run_left_next       = run_left;
    low_byte_hold_next  = low_byte_hold;
    red_hold_next       = red_hold;
    green_hold_next     = green_hold;
    halted_next         = halted;
    fail                = 1'b0;
    fail_code           = ERR_NONE;
    pix                 = 1'b0;
    out_push            = 1'b0;
    out_item            = '0;

    if (in_take && !halted && bytes_left != '0) begin
      case (phase)
        PH_BLANK_LO: begin
          if (bytes_left < SIZE_W'(HEADER_BYTES)) begin
            fail      = 1'b1;
            fail_code = ERR_TRUNCATED;
          end else begin
            low_byte_hold_next = in_byte;
            phase_next         = PH_BLANK_HI;
          end
        end
        PH_BLANK_HI: begin
          if (run_value > 16'(RUN_LIMIT)) begin
            fail      = 1'b1;
            fail_code = ERR_BLANK_BIG;
          end else begin
            pixel_position_next = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
            phase_next          = PH_COUNT_LO;
          end
        end
        PH_COUNT_LO: begin
          low_byte_hold_next = in_byte;
          phase_next         = PH_COUNT_HI;
        end
        PH_COUNT_HI: begin
          if (run_value > 16'(RUN_LIMIT)) begin
            fail      = 1'b1;
            fail_code = ERR_COUNT_BIG;
          end else if (18'(bytes_dec) < triple) begin
            fail      = 1'b1;
            fail_code = ERR_SHORT;
          end else begin
            run_left_next = run_value[RUN_W-1:0];
            phase_next    = (run_value != '0) ? PH_RED : PH_BLANK_LO;
          end
        end
        PH_RED: begin
          red_hold_next = in_byte;
          phase_next    = PH_GREEN;
        end
        PH_GREEN: begin
          green_hold_next = in_byte;
          phase_next      = PH_BLUE;
        end
        PH_BLUE: begin
          if (pixel_position >= POS_W'(PIXELS)) begin
            fail      = 1'b1;
            fail_code = ERR_INDEX;
          end else begin
            pix                 = 1'b1;
            pixel_position_next = pixel_position + 1'b1;
            run_left_next       = run_dec;
            phase_next          = (run_dec != '0) ? PH_RED : PH_BLANK_LO;
          end
        end
        default: begin
          fail      = 1'b1;
          fail_code = ERR_NONE;
        end
      endcase

      if (fail) begin
        halted_next         = 1'b1;
        phase_next          = phase;
        pixel_position_next = pixel_position;
        run_left_next       = run_left;
        out_push            = 1'b1;
        out_item.error_code = fail_code;
      end else begin
        bytes_left_next = bytes_dec;
        if (pix) begin
          out_push             = 1'b1;
          out_item.pixel_valid = 1'b1;
          out_item.pixel_index = pixel_position[INDEX_W-1:0];
          out_item.red         = red_hold;
          out_item.green       = green_hold;
          out_item.blue        = in_byte;
          out_item.alpha       = '1;
        end
        if (bytes_dec == '0) begin
          halted_next       = 1'b1;
          out_push          = 1'b1;
          out_item.finished = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_BLANK_LO;
      bytes_left     <= '0;
      pixel_position <= '0;
      run_left       <= '0;
      halted         <= 1'b1;
    end else if (cfg_write) begin
      phase          <= PH_BLANK_LO;
      bytes_left     <= cfg_size;
      pixel_position <= '0;
      run_left       <= '0;
      halted         <= (cfg_size == '0);
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      pixel_position <= pixel_position_next;
      run_left       <= run_left_next;
      halted         <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    low_byte_hold <= low_byte_hold_next;
    red_hold      <= red_hold_next;
    green_hold    <= green_hold_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rle_sprite_pixel_decoder_unit.sv =====
// Top level of the run-length sprite pixel decoder: byte queue, decoder
// core and result queue. Depends on rsd_pkg, rsd_fifo and rsd_decode.
`default_nettype none

// Decodes one run-length sprite, one encoded byte per beat, into pixel writes
// for an IMAGE_SIDE x IMAGE_SIDE image. Each run is a 16-bit little-endian
// transparent count, a 16-bit colored count and one RGB triplet per colored
// pixel; transparent pixels produce no beat, so the consumer clears its buffer
// first. A beat comes out for each written pixel, for the last byte of the
// sprite (finished) and for the first error, after which bytes are dropped
// until sprite_size is written again. Writing sprite_size restarts decoding;
// write it only while both queues are empty. Throughput is one byte per
// cycle while the result queue is not full, via the combinational decoder
// step between the two-entry byte and result queues, both registered.
module rle_sprite_pixel_decoder_unit
  import rsd_pkg::*;
#(
  parameter int unsigned IMAGE_SIDE = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [SIZE_W-1:0]  sprite_size,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [BYTE_W-1:0]  data_byte,
  output logic                    empty,
  input  wire logic               pop,
  output logic                    pixel_valid,
  output logic [INDEX_W-1:0]      pixel_index,
  output logic [BYTE_W-1:0]       red,
  output logic [BYTE_W-1:0]       green,
  output logic [BYTE_W-1:0]       blue,
  output logic [BYTE_W-1:0]       alpha,
  output logic                    finished,
  output logic [2:0]              error_code
);

  localparam int unsigned QUEUE_DEPTH = 2;

  logic              byte_empty;
  logic [BYTE_W-1:0] byte_head;
  logic              byte_take;
  logic              res_full;
  logic              res_push;
  result_t           res_item;
  logic [RESULT_W-1:0] res_head_bits;
  result_t           res_head;

  rsd_fifo #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_byte_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (data_byte),
    .rd_en   (byte_take),
    .rd_data (byte_head),
    .full    (full),
    .empty   (byte_empty)
  );

  rsd_decode #(
    .IMAGE_SIDE (IMAGE_SIDE)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_size  (sprite_size),
    .in_valid  (!byte_empty),
    .in_byte   (byte_head),
    .in_take   (byte_take),
    .out_full  (res_full),
    .out_push  (res_push),
    .out_item  (res_item)
  );

  rsd_fifo #(
    .WIDTH (RESULT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_item),
    .rd_en   (pop),
    .rd_data (res_head_bits),
    .full    (res_full),
    .empty   (empty)
  );

  assign res_head    = result_t'(res_head_bits);
  assign pixel_valid = res_head.pixel_valid;
  assign pixel_index = res_head.pixel_index;
  assign red         = res_head.red;
  assign green       = res_head.green;
  assign blue        = res_head.blue;
  assign alpha       = res_head.alpha;
  assign finished    = res_head.finished;
  assign error_code  = res_head.error_code;

endmodule

`default_nettype wire
